[rtl/midpoint_circle_raster_assert.svh]
// Assertion macros for the midpoint circle rasterizer checker.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef MIDPOINT_CIRCLE_RASTER_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTER_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define MCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define MCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define MCR_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mcr_pkg.sv]
// Shared constants and types for the midpoint circle rasterizer.
// No dependencies; every other file of the block but the assertion header refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package mcr_pkg;

  localparam int COORD_BITS_DEF = 10;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_W  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_H  = 2'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int CENTER_RESET = 200;
  localparam int IMAGE_RESET  = 400;

  localparam int DEC_INIT  = 3;
  localparam int DEC_SHIFT = 2;
  localparam int DEC_DIAG  = 10;
  localparam int DEC_AXIS  = 6;

  localparam int GROUP_PIXELS = 8;
  localparam int PIX_IDX_BITS = $clog2(GROUP_PIXELS);
  localparam int QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } mcr_q_stat_t;

endpackage

`default_nettype wire

[rtl/mcr_ifs.sv]
// Channel interfaces of the midpoint circle rasterizer: input, result, configuration.
// Depends on mcr_pkg for the default coordinate width and register index width.
`timescale 1ns / 1ps
`default_nettype none

interface mcr_in_if #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] radius;

  modport source (output valid, output op, output radius, input ready);
  modport sink (input valid, input op, input radius, output ready);
endinterface

interface mcr_out_if #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic                         on_image;
  logic                         last;
  logic                         done_res;

  modport source (output valid, output pixel_x, output pixel_y, output on_image,
                  output last, output done_res, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input on_image,
                input last, input done_res, output ready);
endinterface

interface mcr_cfg_if #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [mcr_pkg::CFG_IDX_BITS-1:0]  index;
  logic [COORD_BITS:0]               data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/midpoint_circle_raster.sv]
// Top level of the midpoint circle rasterizer: front part, descriptor queue, back part.
// Depends on mcr_pkg, the channel interfaces, mcr_front, mcr_fifo and mcr_back.
//
//   channel  dir  payload                                       ready
//   in_ch    in   op, radius                                    queue has room
//   out_ch   out  pixel_x, pixel_y, on_image, last, done_res    from sink
//   cfg_ch   in   index, data                                   always high
//
// A start or an emitting step queues one group.
// Each group leaves as eight pixels, one per cycle while out_ch is not stalled, through the output register.
// The queue holds two groups, so items keep arriving while a group drains.
// Synchronous reset clears the octant state and queue and restores the registers.
// A stall on out_ch holds the pixel; in_ch stalls only while the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_raster #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  mcr_in_if.sink      in_ch,
  mcr_out_if.source   out_ch,
  mcr_cfg_if.sink     cfg_ch
);

  localparam int DESC_BITS = 2 * (COORD_BITS + 1) + 1;

  mcr_pkg::mcr_q_stat_t  q_stat;
  logic                  q_push, q_pop;
  logic [DESC_BITS-1:0]  q_push_data, q_head;

  mcr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .in_radius (in_ch.radius),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_data (q_push_data)
  );

  mcr_fifo #(
    .WIDTH (DESC_BITS)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head),
    .q_stat    (q_stat)
  );

  mcr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_data       (q_head),
    .pop          (q_pop),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_pixel_x  (out_ch.pixel_x),
    .out_pixel_y  (out_ch.pixel_y),
    .out_on_image (out_ch.on_image),
    .out_last     (out_ch.last),
    .out_done_res (out_ch.done_res)
  );

endmodule

`default_nettype wire

[rtl/mcr_front.sv]
// Front part: accepts start and step items and advances the octant state.
// Pushes one group descriptor (x, y, done) per emitting item; uses mcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcr_front #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            in_op,
  input  wire [COORD_BITS-1:0]           in_radius,
  input  mcr_pkg::mcr_q_stat_t           q_stat,
  output logic                           push,
  output logic [2*(COORD_BITS+1):0]      push_data
);

  localparam int XY_BITS  = COORD_BITS + 1;
  localparam int DEC_BITS = COORD_BITS + 4;

  logic [XY_BITS-1:0]  x_r, x_nxt;
  logic [XY_BITS-1:0]  y_r, y_nxt;
  logic [DEC_BITS-1:0] d_r, d_nxt;
  logic                active_r, active_nxt;

  logic                accept;
  logic                behind;
  logic                done_new;
  logic [DEC_BITS-1:0] x_ext, y_ext, r_ext;

  assign in_ready = q_stat.not_full;
  assign accept   = in_valid && in_ready;
  assign x_ext    = {{(DEC_BITS-XY_BITS){1'b0}}, x_r};
  assign y_ext    = {{(DEC_BITS-XY_BITS){y_r[XY_BITS-1]}}, y_r};
  assign r_ext    = {{(DEC_BITS-COORD_BITS){1'b0}}, in_radius};

  // The y coordinate is two's complement, x is never negative.
  assign behind   = y_r[XY_BITS-1] || (y_r < x_r);
  assign done_new = y_nxt[XY_BITS-1] || (y_nxt < x_nxt);

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    d_nxt      = d_r;
    active_nxt = active_r;
    push       = 1'b0;
    if (accept) begin
      if (in_op == mcr_pkg::OP_START) begin
        x_nxt      = '0;
        y_nxt      = {1'b0, in_radius};
        d_nxt      = DEC_BITS'(mcr_pkg::DEC_INIT) - (r_ext << 1);
        active_nxt = 1'b1;
        push       = 1'b1;
      end else if (active_r && !behind) begin
        if (!d_r[DEC_BITS-1] && (d_r != '0)) begin
          d_nxt = d_r + ((x_ext - y_ext) << mcr_pkg::DEC_SHIFT)
                  + DEC_BITS'(mcr_pkg::DEC_DIAG);
          y_nxt = y_r - XY_BITS'(1);
        end else begin
          d_nxt = d_r + (x_ext << mcr_pkg::DEC_SHIFT) + DEC_BITS'(mcr_pkg::DEC_AXIS);
        end
        x_nxt = x_r + XY_BITS'(1);
        push  = 1'b1;
      end
      if (push && done_new) begin
        active_nxt = 1'b0;
      end
    end
  end

  assign push_data = {x_nxt, y_nxt, done_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      d_r      <= '0;
      active_r <= 1'b0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      d_r      <= d_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/mcr_fifo.sv]
// Short queue of group descriptors between the front and back parts.
// Uses mcr_pkg for its depth and its status struct.
`timescale 1ns / 1ps
`default_nettype none

module mcr_fifo #(
  parameter int WIDTH = 2 * (mcr_pkg::COORD_BITS_DEF + 1) + 1
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  wire [WIDTH-1:0]       push_data,
  input  wire                   pop,
  output logic [WIDTH-1:0]      head_data,
  output mcr_pkg::mcr_q_stat_t  q_stat
);

  localparam int DEPTH    = mcr_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slot_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign q_stat.not_full  = (cnt_r != CNT_BITS'(DEPTH));
  assign q_stat.not_empty = (cnt_r != '0);
  assign do_push          = push && q_stat.not_full;
  assign do_pop           = pop && q_stat.not_empty;
  assign head_data        = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/mcr_back.sv]
// Back part: holds the configuration and expands each descriptor into eight pixels.
// One pixel per cycle, while the output is free, into a registered output; uses mcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcr_back #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  mcr_pkg::mcr_q_stat_t              q_stat,
  input  wire [2*(COORD_BITS+1):0]          q_data,
  output logic                              pop,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [mcr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire [COORD_BITS:0]                cfg_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [COORD_BITS+1:0]             out_pixel_x,
  output logic [COORD_BITS+1:0]             out_pixel_y,
  output logic                              out_on_image,
  output logic                              out_last,
  output logic                              out_done_res
);

  localparam int XY_BITS  = COORD_BITS + 1;
  localparam int PIX_BITS = COORD_BITS + 2;
  localparam int K_BITS   = mcr_pkg::PIX_IDX_BITS;

  logic [COORD_BITS-1:0] cx_r, cy_r;
  logic [XY_BITS-1:0]    w_r, h_r;

  logic [XY_BITS-1:0]    gx_r, gy_r;
  logic                  gdone_r;
  logic                  busy_r, busy_nxt;
  logic [K_BITS-1:0]     k_r, k_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [PIX_BITS-1:0]   px_r, py_r;
  logic                  on_r, last_r, done_r;

  logic                  out_free, emit, fin;
  logic [PIX_BITS-1:0]   x_zx, y_sx, a_op, b_op, cx_p, cy_p, px, py;
  logic                  on_px;

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid_r || out_ready;
  assign emit     = busy_r && out_free;
  assign fin      = emit && (k_r == K_BITS'(mcr_pkg::GROUP_PIXELS - 1));
  assign pop      = q_stat.not_empty && (!busy_r || fin);

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (pop) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end else if (fin) begin
      busy_nxt = 1'b0;
      k_nxt    = '0;
    end else if (emit) begin
      k_nxt = k_r + K_BITS'(1);
    end
  end

  // Bit 2 of the pixel index swaps x and y, bit 1 negates the column term,
  // bit 0 negates the row term.
  assign x_zx = {1'b0, gx_r};
  assign y_sx = {gy_r[XY_BITS-1], gy_r};
  assign a_op = k_r[2] ? y_sx : x_zx;
  assign b_op = k_r[2] ? x_zx : y_sx;
  assign cx_p = {2'b00, cx_r};
  assign cy_p = {2'b00, cy_r};
  assign px   = k_r[1] ? (cx_p - a_op) : (cx_p + a_op);
  assign py   = k_r[0] ? (cy_p - b_op) : (cy_p + b_op);
  assign on_px = !px[PIX_BITS-1] && (px[PIX_BITS-2:0] < w_r)
              && !py[PIX_BITS-1] && (py[PIX_BITS-2:0] < h_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= COORD_BITS'(mcr_pkg::CENTER_RESET);
      cy_r <= COORD_BITS'(mcr_pkg::CENTER_RESET);
      w_r  <= XY_BITS'(mcr_pkg::IMAGE_RESET);
      h_r  <= XY_BITS'(mcr_pkg::IMAGE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mcr_pkg::REG_CENTER_X: begin
          cx_r <= cfg_data[COORD_BITS-1:0];
        end
        mcr_pkg::REG_CENTER_Y: begin
          cy_r <= cfg_data[COORD_BITS-1:0];
        end
        mcr_pkg::REG_IMAGE_W: begin
          w_r <= cfg_data;
        end
        mcr_pkg::REG_IMAGE_H: begin
          h_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      {gx_r, gy_r, gdone_r} <= q_data;
    end
    if (emit) begin
      px_r   <= px;
      py_r   <= py;
      on_r   <= on_px;
      last_r <= (k_r == K_BITS'(mcr_pkg::GROUP_PIXELS - 1));
      done_r <= gdone_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel_x  = px_r;
  assign out_pixel_y  = py_r;
  assign out_on_image = on_r;
  assign out_last     = last_r;
  assign out_done_res = done_r;

endmodule

`default_nettype wire

[rtl/mcr_checker.sv]
// Port-level checker for the midpoint circle rasterizer and its bind statement.
// Depends on midpoint_circle_raster_assert.svh and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_circle_raster_assert.svh"

module mcr_checker #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [COORD_BITS+1:0] out_pixel_x,
  input wire [COORD_BITS+1:0] out_pixel_y,
  input wire                  out_last,
  input wire                  out_done_res
);

  // A stalled pixel stays offered unchanged.
  `MCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_x) && $stable(out_pixel_y), "stalled pixel changed")

  // The pixels of a group follow one another without a gap.
  `MCR_ASSERT_NEXT(a_group_gapless, out_valid && out_ready && !out_last, out_valid, "gap inside a pixel group")

  // The octant-finished flag is the same for all eight pixels of a group.
  `MCR_ASSERT_NEXT(a_done_steady, out_valid && out_ready && !out_last, out_done_res == $past(out_done_res), "done flag changed inside a group")

  // Reset leaves nothing on the result channel.
  `MCR_ASSERT_ALWAYS(a_reset_quiet, !rst_n, !out_valid, "result offered right after reset")

endmodule

bind midpoint_circle_raster mcr_checker #(
  .COORD_BITS (COORD_BITS)
) u_mcr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_pixel_x  (out_ch.pixel_x),
  .out_pixel_y  (out_ch.pixel_y),
  .out_last     (out_ch.last),
  .out_done_res (out_ch.done_res)
);

`default_nettype wire

[sim/midpoint_circle_raster_tb.sv]
// Self-checking testbench for the midpoint circle rasterizer: directed and random circles.
// Depends on mcr_pkg, the channel interfaces in mcr_ifs.sv and the midpoint_circle_raster top.
`timescale 1ns / 1ps

module midpoint_circle_raster_tb;

  localparam int CB = mcr_pkg::COORD_BITS_DEF;
  localparam int PW = CB + 2;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 200;

  class circle_scoreboard;
    typedef struct {
      logic signed [PW-1:0] px;
      logic signed [PW-1:0] py;
      logic                 on_img;
      logic                 last;
      logic                 fin;
    } pixel_t;

    bit [CB-1:0]        ctr_x;
    bit [CB-1:0]        ctr_y;
    bit [CB:0]          img_w;
    bit [CB:0]          img_h;
    bit [CB:0]          oct_x;
    bit signed [CB:0]   oct_y;
    bit signed [CB+3:0] dec;
    bit                 running;
    pixel_t             pixels_due[$];
    int                 mismatches;
    int                 seen;

    function new();
      ctr_x = CB'(mcr_pkg::CENTER_RESET);
      ctr_y = CB'(mcr_pkg::CENTER_RESET);
      img_w = (CB + 1)'(mcr_pkg::IMAGE_RESET);
      img_h = (CB + 1)'(mcr_pkg::IMAGE_RESET);
      oct_x = '0;
      oct_y = '0;
      dec = '0;
      running = 1'b0;
      mismatches = 0;
      seen = 0;
    endfunction

    function void write_reg(logic [mcr_pkg::CFG_IDX_BITS-1:0] idx, logic [CB:0] data);
      case (idx)
        mcr_pkg::REG_CENTER_X: ctr_x = data[CB-1:0];
        mcr_pkg::REG_CENTER_Y: ctr_y = data[CB-1:0];
        mcr_pkg::REG_IMAGE_W:  img_w = data;
        mcr_pkg::REG_IMAGE_H:  img_h = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    // Queues the eight mirrored pixels of the current octant point.
    function void push_group();
      int     x;
      int     y;
      int     cx;
      int     cy;
      int     px[mcr_pkg::GROUP_PIXELS];
      int     py[mcr_pkg::GROUP_PIXELS];
      pixel_t p;
      bit     fin;
      x = int'(oct_x);
      y = int'(oct_y);
      cx = int'(ctr_x);
      cy = int'(ctr_y);
      fin = (y < x);
      px = '{cx + x, cx + x, cx - x, cx - x, cx + y, cx + y, cx - y, cx - y};
      py = '{cy + y, cy - y, cy + y, cy - y, cy + x, cy - x, cy + x, cy - x};
      for (int k = 0; k < mcr_pkg::GROUP_PIXELS; k++) begin
        p.px = px[k][PW-1:0];
        p.py = py[k][PW-1:0];
        p.on_img = (px[k] >= 0) && (px[k] < int'(img_w)) &&
                   (py[k] >= 0) && (py[k] < int'(img_h));
        p.last = (k == mcr_pkg::GROUP_PIXELS - 1);
        p.fin = fin;
        pixels_due.push_back(p);
      end
      if (fin) begin
        running = 1'b0;
      end
    endfunction

    function void note_item(logic op, logic [CB-1:0] r);
      int x;
      int y;
      int d;
      if (op == mcr_pkg::OP_START) begin
        d = mcr_pkg::DEC_INIT - 2 * int'(r);
        oct_x = '0;
        oct_y = {1'b0, r};
        dec = d[CB+3:0];
        running = 1'b1;
        push_group();
      end else begin
        x = int'(oct_x);
        y = int'(oct_y);
        d = int'(dec);
        if (!running || y < x) begin
          return;
        end
        // The update uses the point from before the step.
        if (d > 0) begin
          d = d + 4 * (x - y) + mcr_pkg::DEC_DIAG;
          y = y - 1;
        end else begin
          d = d + 4 * x + mcr_pkg::DEC_AXIS;
        end
        x = x + 1;
        oct_x = x[CB:0];
        oct_y = y[CB:0];
        dec = d[CB+3:0];
        push_group();
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t ERROR: %s", $time, what);
      end
    endtask

    task check_pixel(input logic signed [PW-1:0] px, input logic signed [PW-1:0] py,
                     input logic on_img, input logic last, input logic fin);
      pixel_t e;
      seen++;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel %0d (%0d,%0d) arrived with nothing expected", seen, px, py));
        return;
      end
      e = pixels_due.pop_front();
      if (px !== e.px) begin
        report($sformatf("pixel %0d pixel_x got %0d expected %0d", seen, px, e.px));
      end
      if (py !== e.py) begin
        report($sformatf("pixel %0d pixel_y got %0d expected %0d", seen, py, e.py));
      end
      if (on_img !== e.on_img) begin
        report($sformatf("pixel %0d on_image got %b expected %b", seen, on_img, e.on_img));
      end
      if (last !== e.last) begin
        report($sformatf("pixel %0d last got %b expected %b", seen, last, e.last));
      end
      if (fin !== e.fin) begin
        report($sformatf("pixel %0d done_res got %b expected %b", seen, fin, e.fin));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  circle_scoreboard sb = new();

  mcr_in_if  in_if();
  mcr_out_if out_if();
  mcr_cfg_if cfg_if();

  midpoint_circle_raster dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Every transfer on the three channels is observed here, at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(cfg_if.index, cfg_if.data);
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_item(in_if.op, in_if.radius);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_pixel(out_if.pixel_x, out_if.pixel_y, out_if.on_image, out_if.last,
                       out_if.done_res);
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic send_item(logic op, logic [CB-1:0] r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.op = op;
    in_if.radius = r;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_step();
    send_item(mcr_pkg::OP_STEP, CB'($urandom_range(2 ** CB - 1)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [mcr_pkg::CFG_IDX_BITS-1:0] idx, logic [CB:0] data);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic set_config(int cx, int cy, int w, int h);
    write_reg(mcr_pkg::REG_CENTER_X, (CB + 1)'(cx));
    write_reg(mcr_pkg::REG_CENTER_Y, (CB + 1)'(cy));
    write_reg(mcr_pkg::REG_IMAGE_W, (CB + 1)'(w));
    write_reg(mcr_pkg::REG_IMAGE_H, (CB + 1)'(h));
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Mostly whole circles of small radius, some cut short by a restart, with stray steps.
  task automatic run_circles(int n_items, bit pause_midway);
    int count;
    int kind;
    int r;
    int oct;
    int steps;
    count = 2;
    send_item(mcr_pkg::OP_START, '1);
    send_step();
    while (count < n_items) begin
      if (pause_midway && count >= n_items / 2) begin
        drain();
        pause_midway = 1'b0;
      end
      kind = $urandom_range(99);
      if (kind < 8) begin
        send_step();
        count++;
      end else begin
        if (kind < 60) begin
          r = $urandom_range(24);
        end else if (kind < 88) begin
          r = $urandom_range(120, 25);
        end else begin
          r = $urandom_range(2 ** CB - 1);
        end
        oct = r * 3 / 4 + 2;
        if (r > 120) begin
          steps = $urandom_range(12);
        end else if ($urandom_range(4) == 0) begin
          steps = $urandom_range(oct);
        end else begin
          steps = $urandom_range(oct + 3, oct);
        end
        if (steps > n_items - count - 1) begin
          steps = n_items - count - 1;
        end
        send_item(mcr_pkg::OP_START, r[CB-1:0]);
        count++;
        repeat (steps) begin
          send_step();
          count++;
        end
      end
    end
    drain();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.op = mcr_pkg::OP_START;
    in_if.radius = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = mcr_pkg::REG_CENTER_X;
    cfg_if.data = '0;
    set_idling(33, 86);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset configuration.
    send_item(mcr_pkg::OP_STEP, '1);
    send_item(mcr_pkg::OP_START, '0);
    send_item(mcr_pkg::OP_STEP, '0);
    send_item(mcr_pkg::OP_STEP, '0);
    send_item(mcr_pkg::OP_START, '1);
    repeat (3) send_step();
    send_item(mcr_pkg::OP_START, CB'(5));
    repeat (6) send_step();
    send_item(mcr_pkg::OP_START, CB'(3));
    send_step();
    send_item(mcr_pkg::OP_START, CB'(700));
    send_step();
    drain();

    set_config(0, 0, 1024, 1024);
    run_circles(62, 1'b0);
    set_config(1023, 1023, 1, 1);
    run_circles(62, 1'b1);

    set_idling(86, 33);
    set_config($urandom_range(1023), $urandom_range(1023), 0, 0);
    run_circles(62, 1'b0);
    set_config(1024 + $urandom_range(1023), $urandom_range(2047), 2047,
               $urandom_range(1024, 1));
    run_circles(62, 1'b0);

    set_idling(0, 0);
    set_config($urandom_range(1023), $urandom_range(1023), $urandom_range(1024, 1),
               $urandom_range(1024, 1));
    run_circles(62, 1'b0);
    set_config($urandom_range(1023), $urandom_range(1023), $urandom_range(1024, 1),
               $urandom_range(1024, 1));
    run_circles(62, 1'b0);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
